[rtl/core/urs_pkg.sv]
// urs_pkg: constants, types and codes for the combined shuffle generator
// used by urs_lcg_unit, the top level and the checker; no dependencies
package urs_pkg;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned VAL_W = 31;

	localparam logic [31:0] MOD_A = 32'd2147483563;
	localparam logic [31:0] MOD_B = 32'd2147483399;
	localparam logic [15:0] MUL_A = 16'd40014;
	localparam logic [15:0] MUL_B = 16'd40692;
	localparam logic [15:0] QUO_A = 16'd53668;
	localparam logic [15:0] QUO_B = 16'd52774;
	localparam logic [13:0] REM_A = 14'd12211;
	localparam logic [13:0] REM_B = 14'd3791;
	localparam logic [VAL_W-1:0] SEED_B = 31'd123456789;
	localparam logic [VAL_W-1:0] SPAN = 31'd2147483562;

	// reciprocals of the schrage quotients, scaled by 2^47
	localparam int unsigned RECIP_SH = 47;
	localparam logic [31:0] RECIP_A = 32'((64'd1 << RECIP_SH) / 64'd53668);
	localparam logic [31:0] RECIP_B = 32'((64'd1 << RECIP_SH) / 64'd52774);

	typedef enum logic {
		CMD_DRAW,
		CMD_RESEED
	} cmd_t;

	typedef enum logic {
		GEN_A,
		GEN_B
	} gen_sel_t;

	typedef struct packed {
		logic             valid;
		gen_sel_t         sel;
		logic [VAL_W-1:0] z;
	} lcg_req_t;

	typedef struct packed {
		logic             valid;
		gen_sel_t         sel;
		logic [VAL_W-1:0] value;
	} lcg_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RS_ISSUE,
		ST_RS_WAIT,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_DRAW_WAIT
	} state_t;

endpackage

[rtl/core/urs_lcg_unit.sv]
// urs_lcg_unit: five-stage pipelined schrage step shared by both generators
// depends on urs_pkg for moduli, multipliers and request/result types
module urs_lcg_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  urs_pkg::lcg_req_t req,
	output urs_pkg::lcg_res_t res
);

	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	urs_pkg::gen_sel_t      sel_s1, sel_s2, sel_s3, sel_s4, sel_s5;
	logic [62:0]            prod_s1;
	logic [30:0]            z_s1, z_s2;
	logic [15:0]            k_s2, k_s3;
	logic [31:0]            t_s2;
	logic [15:0]            m_s3;
	logic [31:0]            a_s4;
	logic [29:0]            b_s4;
	logic [30:0]            value_s5;

	logic [31:0]            recip;
	logic [15:0]            k_est;
	logic [15:0]            quo_s2;
	logic [31:0]            diff;
	logic [15:0]            mul_s3;
	logic [13:0]            rem_s3;
	logic signed [32:0]     r_raw;
	logic signed [32:0]     r_fix;

	assign recip  = (req.sel == urs_pkg::GEN_A) ? urs_pkg::RECIP_A : urs_pkg::RECIP_B;
	assign k_est  = prod_s1[62:47];
	assign quo_s2 = (sel_s2 == urs_pkg::GEN_A) ? urs_pkg::QUO_A : urs_pkg::QUO_B;
	assign diff   = {1'b0, z_s2} - t_s2;
	assign mul_s3 = (sel_s3 == urs_pkg::GEN_A) ? urs_pkg::MUL_A : urs_pkg::MUL_B;
	assign rem_s3 = (sel_s3 == urs_pkg::GEN_A) ? urs_pkg::REM_A : urs_pkg::REM_B;

	always_comb begin
		r_raw = $signed({1'b0, a_s4}) - $signed({3'b000, b_s4});
		if (r_raw < 0) begin
			if (sel_s4 == urs_pkg::GEN_A) begin
				r_fix = r_raw + $signed({1'b0, urs_pkg::MOD_A});
			end else begin
				r_fix = r_raw + $signed({1'b0, urs_pkg::MOD_B});
			end
		end else begin
			r_fix = r_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// quotient estimate by reciprocal
		sel_s1  <= req.sel;
		z_s1    <= req.z;
		prod_s1 <= {32'b0, req.z} * {31'b0, recip};
		// back-multiply
		sel_s2  <= sel_s1;
		z_s2    <= z_s1;
		k_s2    <= k_est;
		t_s2    <= 32'({16'b0, k_est} * {16'b0, (sel_s1 == urs_pkg::GEN_A) ?
			urs_pkg::QUO_A : urs_pkg::QUO_B});
		// one-step correction of quotient and remainder
		sel_s3  <= sel_s2;
		if (diff >= {16'b0, quo_s2}) begin
			k_s3 <= k_s2 + 16'd1;
			m_s3 <= 16'(diff - {16'b0, quo_s2});
		end else begin
			k_s3 <= k_s2;
			m_s3 <= diff[15:0];
		end
		// schrage partial products
		sel_s4  <= sel_s3;
		a_s4    <= {16'b0, mul_s3} * {16'b0, m_s3};
		b_s4    <= 30'({14'b0, k_s3} * {16'b0, rem_s3});
		// subtract and wrap
		sel_s5   <= sel_s4;
		value_s5 <= r_fix[30:0];
	end

	assign res.valid = valid_s5;
	assign res.sel   = sel_s5;
	assign res.value = value_s5;

endmodule

[rtl/core/uniform_random_shuffle_generator_top.sv]
// uniform_random_shuffle_generator_top: two combined congruential generators
// with a shuffle table held in a synchronous ram; uses urs_pkg, urs_lcg_unit
// draw: strobe once both generators have stepped; no new draw is taken while busy
// reseed: adds a run of dependent generator steps, one step per pass through
// the 5-stage multiply unit
// no backpressure on results; reset clears the table at once through
// per-entry valid flops, no clearing pass
module uniform_random_shuffle_generator_top #(
	parameter int unsigned TABLE_DEPTH = urs_pkg::TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [30:0] seed_value,
	output logic        strobe,
	output logic [30:0] random_value
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 8);
	localparam logic [31:0] BUCKET = 32'(64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH));
	localparam logic [17:0] JMUL = 18'((64'd1 << 40) / 64'(BUCKET));
	localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);

	urs_pkg::state_t    state_q, state_d;
	urs_pkg::lcg_req_t  req;
	urs_pkg::lcg_res_t  res;

	logic [30:0]        first_q, second_q, last_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               strobe_q;
	logic [30:0]        random_value_q;

	logic [30:0]        tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [30:0]        rd_data_s4;
	logic               rd_valid_s4;
	logic               tbl_we;
	logic [IDX_W-1:0]   tbl_waddr;
	logic [30:0]        tbl_wdata;

	logic [48:0]        jprod_s1;
	logic [30:0]        jlast_s1, jlast_s2;
	logic [8:0]         jest_s2;
	logic [31:0]        jback_s2;
	logic [IDX_W-1:0]   j_s3;
	logic [31:0]        jrem;
	logic [8:0]         jfull;

	logic [30:0]        seed_sel, seed_eff;
	logic               reseed_cmd;
	logic [30:0]        entry;
	logic signed [32:0] ydiff, ywrap;
	logic [30:0]        y;
	logic               rs_write;

	urs_lcg_unit u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	assign reseed_cmd = (command == urs_pkg::CMD_RESEED);
	assign seed_sel   = reseed_cmd ? seed_value : 31'd1;
	assign seed_eff   = (seed_sel == 31'd0) ? 31'd1 : seed_sel;

	// table index from the previous output, free running
	assign jrem  = {1'b0, jlast_s2} - jback_s2;
	assign jfull = jest_s2 + {8'b0, (jrem >= BUCKET)};

	always_ff @(posedge clk) begin
		jprod_s1 <= {18'b0, last_q} * {31'b0, JMUL};
		jlast_s1 <= last_q;
		jest_s2  <= jprod_s1[48:40];
		jback_s2 <= 32'({23'b0, jprod_s1[48:40]} * BUCKET);
		jlast_s2 <= jlast_s1;
		if (jfull >= DEPTH_9) begin
			j_s3 <= IDX_W'(TABLE_DEPTH - 1);
		end else begin
			j_s3 <= jfull[IDX_W-1:0];
		end
	end

	// shuffle table
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		rd_data_s4  <= tbl_mem[j_s3];
		rd_valid_s4 <= valid_q[j_s3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (tbl_we) begin
			valid_q[tbl_waddr] <= 1'b1;
		end
	end

	assign entry = rd_valid_s4 ? rd_data_s4 : 31'd0;

	always_comb begin
		ydiff = $signed({2'b00, entry}) - $signed({2'b00, res.value});
		if (ydiff < 33'sd1) begin
			ywrap = ydiff + $signed({2'b00, urs_pkg::SPAN});
		end else begin
			ywrap = ydiff;
		end
		if (ywrap < 33'sd1) begin
			y = 31'd1;
		end else if (ywrap > $signed({2'b00, urs_pkg::SPAN})) begin
			y = urs_pkg::SPAN;
		end else begin
			y = ywrap[30:0];
		end
	end

	assign rs_write = (state_q == urs_pkg::ST_RS_WAIT) && res.valid &&
		(cnt_q < CNT_W'(TABLE_DEPTH));

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = j_s3;
		tbl_wdata = first_q;
		if (rs_write) begin
			tbl_we    = 1'b1;
			tbl_waddr = cnt_q[IDX_W-1:0];
			tbl_wdata = res.value;
		end else if ((state_q == urs_pkg::ST_DRAW_WAIT) && res.valid &&
			(res.sel == urs_pkg::GEN_B)) begin
			tbl_we = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.valid = 1'b0;
		req.sel   = urs_pkg::GEN_A;
		req.z     = first_q;
		unique case (state_q)
			urs_pkg::ST_IDLE: begin
				if (start) begin
					if (reseed_cmd || (first_q == 31'd0)) begin
						state_d = urs_pkg::ST_RS_ISSUE;
					end else begin
						state_d = urs_pkg::ST_DRAW_A;
					end
				end
			end
			urs_pkg::ST_RS_ISSUE: begin
				req.valid = 1'b1;
				state_d   = urs_pkg::ST_RS_WAIT;
			end
			urs_pkg::ST_RS_WAIT: begin
				if (res.valid) begin
					if (cnt_q == '0) begin
						state_d = urs_pkg::ST_DRAW_A;
					end else begin
						state_d = urs_pkg::ST_RS_ISSUE;
					end
				end
			end
			urs_pkg::ST_DRAW_A: begin
				req.valid = 1'b1;
				state_d   = urs_pkg::ST_DRAW_B;
			end
			urs_pkg::ST_DRAW_B: begin
				req.valid = 1'b1;
				req.sel   = urs_pkg::GEN_B;
				req.z     = second_q;
				state_d   = urs_pkg::ST_DRAW_WAIT;
			end
			urs_pkg::ST_DRAW_WAIT: begin
				if (res.valid && (res.sel == urs_pkg::GEN_B)) begin
					state_d = urs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = urs_pkg::ST_IDLE;
			end
		endcase
	end

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 31'd1;
			second_q <= urs_pkg::SEED_B;
			last_q   <= 31'd0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if ((state_q == urs_pkg::ST_IDLE) && start &&
				(reseed_cmd || (first_q == 31'd0))) begin
				first_q  <= seed_eff;
				second_q <= seed_eff;
				cnt_q    <= CNT_W'(TABLE_DEPTH + 7);
			end
			if ((state_q == urs_pkg::ST_RS_WAIT) && res.valid) begin
				first_q <= res.value;
				if (cnt_q == '0) begin
					last_q <= res.value;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if ((state_q == urs_pkg::ST_DRAW_WAIT) && res.valid) begin
				if (res.sel == urs_pkg::GEN_A) begin
					first_q <= res.value;
				end else begin
					second_q <= res.value;
					last_q   <= y;
					strobe_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == urs_pkg::ST_DRAW_WAIT) && res.valid &&
			(res.sel == urs_pkg::GEN_B)) begin
			random_value_q <= y;
		end
	end

	assign busy         = (state_q != urs_pkg::ST_IDLE);
	assign strobe       = strobe_q;
	assign random_value = random_value_q;

endmodule

[rtl/core/urs_checker.sv]
// urs_checker: port-level assertions on the shuffle generator top level
// depends on urs_pkg; bound to uniform_random_shuffle_generator_top below
module urs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [30:0] random_value
);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((random_value != 31'd0) && (random_value <= urs_pkg::SPAN)))
		else $error("result beat outside 1..span");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result beats");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result beat while busy");

	a_done_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("busy dropped without a result beat");

endmodule

bind uniform_random_shuffle_generator_top urs_checker u_urs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.random_value (random_value)
);
